FILE: hdl/pmr_pkg.sv
// Shared widths, codes, state type and saturation helper for the pointer motion to report block.
package pmr_pkg;

    localparam int DELTA_W    = 16;
    localparam int WIDE_W     = DELTA_W + 1;
    localparam int LAYER_W    = 8;
    localparam int DIVISOR_W  = 8;
    localparam int SDIV_W     = 5;
    localparam int SREM_W     = 5;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int OUT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DIV_STEPS  = DELTA_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION_DIVISOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_LAYER       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DIVISOR     = 2'd2;

    localparam logic [DIVISOR_W-1:0] RESOLUTION_DIVISOR_RESET = 8'd1;
    localparam logic [LAYER_W-1:0]   SCROLL_LAYER_RESET       = 8'd255;
    localparam logic [SDIV_W-1:0]    SCROLL_DIVISOR_RESET     = 5'd5;
    localparam logic [SDIV_W-1:0]    SCROLL_DIVISOR_MAX       = 5'd16;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 17'sd127;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -17'sd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCROLL,
        ST_DELIVER
    } pmr_state_t;

    function automatic logic signed [OUT_W-1:0] sat8(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end else begin
            c = v;
        end
        return OUT_W'(c);
    endfunction

endpackage

FILE: hdl/pointer_motion_to_report.sv
// Top level: turns one sensor motion sample into a pointer movement or scroll report.
//
// A sample whose deltas are both zero is taken and yields no report. Any other sample is
// scaled by the resolution divisor on two bit-serial divider lanes (x and y side by side,
// a pass of 16 steps), and a movement report is then written to the output register; on
// the scroll layer the lanes run a second pass with the scroll divisor before the report is
// written. One sample is in work at a time; the input is ready again once the report sits
// in the output register, even before it has been taken, and a report that is due waits
// while an earlier report still waits in the output register.
module pointer_motion_to_report (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic        [pmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [pmr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pmr_pkg::DELTA_W-1:0]    s_delta_x,
    input  logic signed [pmr_pkg::DELTA_W-1:0]    s_delta_y,
    input  logic        [pmr_pkg::LAYER_W-1:0]    s_active_layer,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pmr_pkg::OUT_W-1:0]      m_move_x,
    output logic signed [pmr_pkg::OUT_W-1:0]      m_move_y,
    output logic signed [pmr_pkg::OUT_W-1:0]      m_scroll_horizontal,
    output logic signed [pmr_pkg::OUT_W-1:0]      m_scroll_vertical
);

    localparam int PAD_W = pmr_pkg::WIDE_W - pmr_pkg::SREM_W;

    pmr_pkg::pmr_state_t                   state_reg, state_next;
    logic                                  scroll_mode_reg, scroll_mode_next;
    logic [pmr_pkg::DIVISOR_W-1:0]         resolution_divisor_reg;
    logic [pmr_pkg::LAYER_W-1:0]           scroll_layer_reg;
    logic [pmr_pkg::SDIV_W-1:0]            scroll_divisor_reg;
    logic signed [pmr_pkg::SREM_W-1:0]     horizontal_remainder_reg, horizontal_remainder_next;
    logic signed [pmr_pkg::SREM_W-1:0]     vertical_remainder_reg, vertical_remainder_next;
    logic                                  m_valid_reg, m_valid_next;
    logic signed [pmr_pkg::OUT_W-1:0]      m_move_x_reg, m_move_x_next;
    logic signed [pmr_pkg::OUT_W-1:0]      m_move_y_reg, m_move_y_next;
    logic signed [pmr_pkg::OUT_W-1:0]      m_scroll_h_reg, m_scroll_h_next;
    logic signed [pmr_pkg::OUT_W-1:0]      m_scroll_v_reg, m_scroll_v_next;

    logic                                  accept;
    logic                                  raw_zero;
    logic [pmr_pkg::DIVISOR_W-1:0]         rdiv_eff;
    logic [pmr_pkg::DIVISOR_W-1:0]         sdiv_eff;
    logic signed [pmr_pkg::WIDE_W-1:0]     th;
    logic signed [pmr_pkg::WIDE_W-1:0]     tv;
    logic                                  div_start;
    logic signed [pmr_pkg::WIDE_W-1:0]     dvd_x;
    logic signed [pmr_pkg::WIDE_W-1:0]     dvd_y;
    logic [pmr_pkg::DIVISOR_W-1:0]         dvs;
    logic                                  done_x;
    logic                                  done_y;
    logic signed [pmr_pkg::WIDE_W-1:0]     q_x;
    logic signed [pmr_pkg::WIDE_W-1:0]     q_y;
    logic signed [pmr_pkg::REM_W-1:0]      r_x;
    logic signed [pmr_pkg::REM_W-1:0]      r_y;

    assign s_ready  = (state_reg == pmr_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign raw_zero = (s_delta_x == '0) && (s_delta_y == '0);

    assign rdiv_eff = (resolution_divisor_reg == '0) ? pmr_pkg::DIVISOR_W'(1)
                                                     : resolution_divisor_reg;
    assign sdiv_eff = (scroll_divisor_reg == '0) ? pmr_pkg::DIVISOR_W'(1)
                    : (scroll_divisor_reg > pmr_pkg::SCROLL_DIVISOR_MAX)
                        ? pmr_pkg::DIVISOR_W'(pmr_pkg::SCROLL_DIVISOR_MAX)
                        : pmr_pkg::DIVISOR_W'(scroll_divisor_reg);

    assign th = q_x + $signed({{PAD_W{horizontal_remainder_reg[pmr_pkg::SREM_W-1]}},
                               horizontal_remainder_reg});
    assign tv = $signed({{PAD_W{vertical_remainder_reg[pmr_pkg::SREM_W-1]}},
                         vertical_remainder_reg}) - q_y;

    assign dvd_x = s_ready ? $signed({s_delta_x[pmr_pkg::DELTA_W-1], s_delta_x}) : th;
    assign dvd_y = s_ready ? $signed({s_delta_y[pmr_pkg::DELTA_W-1], s_delta_y}) : tv;
    assign dvs   = s_ready ? rdiv_eff : sdiv_eff;

    assign div_start = (accept && !raw_zero)
                    || (state_reg == pmr_pkg::ST_SCALE && done_x && scroll_mode_reg);

    pmr_div_lane u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_x),
        .divisor   (dvs),
        .done      (done_x),
        .quotient  (q_x),
        .remainder (r_x)
    );

    pmr_div_lane u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_y),
        .divisor   (dvs),
        .done      (done_y),
        .quotient  (q_y),
        .remainder (r_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_divisor_reg <= pmr_pkg::RESOLUTION_DIVISOR_RESET;
            scroll_layer_reg       <= pmr_pkg::SCROLL_LAYER_RESET;
            scroll_divisor_reg     <= pmr_pkg::SCROLL_DIVISOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pmr_pkg::CFG_RESOLUTION_DIVISOR: begin
                    resolution_divisor_reg <= cfg_data;
                end
                pmr_pkg::CFG_SCROLL_LAYER: begin
                    scroll_layer_reg <= cfg_data;
                end
                pmr_pkg::CFG_SCROLL_DIVISOR: begin
                    scroll_divisor_reg <= cfg_data[pmr_pkg::SDIV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next                = state_reg;
        scroll_mode_next          = scroll_mode_reg;
        horizontal_remainder_next = horizontal_remainder_reg;
        vertical_remainder_next   = vertical_remainder_reg;
        m_valid_next              = m_valid_reg && !m_ready;
        m_move_x_next             = m_move_x_reg;
        m_move_y_next             = m_move_y_reg;
        m_scroll_h_next           = m_scroll_h_reg;
        m_scroll_v_next           = m_scroll_v_reg;
        unique case (state_reg)
            pmr_pkg::ST_IDLE: begin
                if (accept && !raw_zero) begin
                    scroll_mode_next = (s_active_layer == scroll_layer_reg);
                    state_next       = pmr_pkg::ST_SCALE;
                end
            end
            pmr_pkg::ST_SCALE: begin
                if (done_x) begin
                    state_next = scroll_mode_reg ? pmr_pkg::ST_SCROLL : pmr_pkg::ST_DELIVER;
                end
            end
            pmr_pkg::ST_SCROLL: begin
                if (done_x) begin
                    horizontal_remainder_next = r_x[pmr_pkg::SREM_W-1:0];
                    vertical_remainder_next   = r_y[pmr_pkg::SREM_W-1:0];
                    state_next                = pmr_pkg::ST_DELIVER;
                end
            end
            pmr_pkg::ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (scroll_mode_reg) begin
                        m_move_x_next   = '0;
                        m_move_y_next   = '0;
                        m_scroll_h_next = pmr_pkg::sat8(q_x);
                        m_scroll_v_next = pmr_pkg::sat8(q_y);
                    end else begin
                        m_move_x_next   = pmr_pkg::sat8(q_x);
                        m_move_y_next   = pmr_pkg::sat8(q_y);
                        m_scroll_h_next = '0;
                        m_scroll_v_next = '0;
                    end
                    state_next = pmr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                <= pmr_pkg::ST_IDLE;
            scroll_mode_reg          <= 1'b0;
            horizontal_remainder_reg <= '0;
            vertical_remainder_reg   <= '0;
            m_valid_reg              <= 1'b0;
        end else begin
            state_reg                <= state_next;
            scroll_mode_reg          <= scroll_mode_next;
            horizontal_remainder_reg <= horizontal_remainder_next;
            vertical_remainder_reg   <= vertical_remainder_next;
            m_valid_reg              <= m_valid_next;
        end
        m_move_x_reg   <= m_move_x_next;
        m_move_y_reg   <= m_move_y_next;
        m_scroll_h_reg <= m_scroll_h_next;
        m_scroll_v_reg <= m_scroll_v_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_move_x            = m_move_x_reg;
    assign m_move_y            = m_move_y_reg;
    assign m_scroll_horizontal = m_scroll_h_reg;
    assign m_scroll_vertical   = m_scroll_v_reg;

`ifndef NO_ASSERTIONS
    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_x == done_y)
        else $error("divider lanes out of step");

    a_zero_sample_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && raw_zero |=> state_reg == pmr_pkg::ST_IDLE)
        else $error("zero sample started work");

    a_remainder_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        horizontal_remainder_reg != 5'sb10000 && vertical_remainder_reg != 5'sb10000)
        else $error("scroll remainder out of range");

    a_one_mode_per_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_scroll_horizontal != '0 || m_scroll_vertical != '0)
        |-> m_move_x == '0 && m_move_y == '0)
        else $error("report carries both movement and scroll");

    a_remainder_held_in_move: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != pmr_pkg::ST_SCROLL |=> $stable(horizontal_remainder_reg)
        && $stable(vertical_remainder_reg))
        else $error("remainder changed outside scroll pass");
`endif

endmodule

FILE: hdl/pmr_div_lane.sv
// Bit-serial signed divider lane: restoring division of the magnitude, one quotient bit per cycle.
module pmr_div_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [pmr_pkg::WIDE_W-1:0]    dividend,
    input  logic        [pmr_pkg::DIVISOR_W-1:0] divisor,
    output logic                                 done,
    output logic signed [pmr_pkg::WIDE_W-1:0]    quotient,
    output logic signed [pmr_pkg::REM_W-1:0]     remainder
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [pmr_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic [pmr_pkg::DELTA_W-1:0]         shift_reg, shift_next;
    logic [pmr_pkg::DIVISOR_W-1:0]       rem_reg, rem_next;
    logic [pmr_pkg::DIVISOR_W-1:0]       divisor_reg, divisor_next;

    logic [pmr_pkg::WIDE_W-1:0]          dvd_u;
    logic [pmr_pkg::WIDE_W-1:0]          mag;
    logic [pmr_pkg::REM_W-1:0]           trial;
    logic [pmr_pkg::REM_W-1:0]           diff;
    logic                                fits;
    logic [pmr_pkg::WIDE_W-1:0]          q_u;
    logic [pmr_pkg::REM_W-1:0]           r_u;

    assign dvd_u = dividend;
    assign mag   = dvd_u[pmr_pkg::WIDE_W-1] ? (~dvd_u + pmr_pkg::WIDE_W'(1)) : dvd_u;
    assign trial = {rem_reg, shift_reg[pmr_pkg::DELTA_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            neg_next     = dvd_u[pmr_pkg::WIDE_W-1];
            shift_next   = mag[pmr_pkg::DELTA_W-1:0];
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[pmr_pkg::DELTA_W-2:0], fits};
            rem_next   = fits ? diff[pmr_pkg::DIVISOR_W-1:0] : trial[pmr_pkg::DIVISOR_W-1:0];
            cnt_next   = cnt_reg + pmr_pkg::CNT_W'(1);
            if (cnt_reg == pmr_pkg::DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg     <= neg_next;
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign q_u       = {1'b0, shift_reg};
    assign r_u       = {1'b0, rem_reg};
    assign done      = done_reg;
    assign quotient  = signed'(neg_reg ? (~q_u + pmr_pkg::WIDE_W'(1)) : q_u);
    assign remainder = signed'(neg_reg ? (~r_u + pmr_pkg::REM_W'(1)) : r_u);

endmodule
